### sv/ppu_pkg.sv
// Shared types, constants and helpers for the particle pool update block.
package ppu_pkg;

  localparam int PPU_POOL_SIZE = 64;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] acc_x;
    logic signed [31:0] acc_y;
    logic signed [31:0] acc_z;
    logic [15:0]        life;
    logic [15:0]        age;
    logic [63:0]        look;
  } particle_t;

  typedef struct packed {
    logic shr;
    logic shl;
    logic wr;
  } cell_ctl_t;

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) begin
      sat_add = s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      sat_add = s[31:0];
    end
  endfunction

endpackage

### sv/ppu_cell.sv
// One pool slot: holds a particle and shifts toward either neighbor.
module ppu_cell
  import ppu_pkg::*;
#(
  parameter int IDX = 0,
  parameter int IW  = 6
) (
  input  logic          clk,
  input  cell_ctl_t     ctl,
  input  logic [IW-1:0] wr_idx,
  input  particle_t     left,
  input  particle_t     right,
  input  particle_t     wdata,
  output particle_t     q
);

  always_ff @(posedge clk) begin
    if (ctl.shr) begin
      q <= left;
    end else if (ctl.shl) begin
      q <= right;
    end else if (ctl.wr && wr_idx == IW'(IDX)) begin
      q <= wdata;
    end
  end

endmodule

### sv/ppu_div.sv
// Restoring divider, one quotient bit per cycle.
module ppu_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [15:0] den,
  output logic        busy,
  output logic [31:0] quot
);

  logic [16:0] rem;
  logic [15:0] dq;
  logic [5:0]  cnt;
  logic [16:0] rem_sh;
  logic [17:0] diff;

  assign rem_sh = {rem[15:0], quot[31]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dq};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 6'd32;
      rem  <= '0;
      quot <= num;
      dq   <= den;
    end else if (busy) begin
      if (!diff[17]) begin
        rem <= diff[16:0];
      end else begin
        rem <= rem_sh;
      end
      quot <= {quot[30:0], ~diff[17]};
      cnt  <= cnt - 6'd1;
      if (cnt == 6'd1) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

### sv/particle_pool_update_core.sv
// Top level: particle pool kept in a chain of slots, with a shared update unit.
//
// Input channel (in_valid/in_stall) takes one beat per command. cmd 0 adds a
// particle at the front of the pool; a full pool refuses it and sets the
// sticky overflow flag. cmd 1 is a frame tick. A tick walks the pool newest
// first: each slot rotates out of the head of the chain, dropped ones leave
// the pool from the head state, survivors pass the position update and the
// 32-step serial divider for the scale. One output beat per survivor, last on
// the final one, overflow reported on each and then cleared. in_stall is high
// until a tick ends.
// The output register holds a beat until out_stall is low; the update unit
// waits for it, so stalling the receiver only stretches the tick.
// Reset empties the pool and clears the sticky overflow flag; slot contents are not cleared.
module particle_pool_update_core
  import ppu_pkg::*;
#(
  parameter int POOL_SIZE = PPU_POOL_SIZE
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               cmd,
  input  logic [15:0]        life,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [31:0] vel_x,
  input  logic signed [31:0] vel_y,
  input  logic signed [31:0] vel_z,
  input  logic signed [31:0] acc_x,
  input  logic signed [31:0] acc_y,
  input  logic signed [31:0] acc_z,
  input  logic [63:0]        appearance,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic signed [16:0] out_scale,
  output logic [31:0]        out_color,
  output logic               overflow,
  output logic               last
);

  localparam int CW = $clog2(POOL_SIZE + 1);
  localparam int IW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_HEAD = 3'd1;
  localparam logic [2:0] S_POS  = 3'd2;
  localparam logic [2:0] S_DIVS = 3'd3;
  localparam logic [2:0] S_DIVW = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  logic [2:0]           state;
  logic [CW-1:0]        count;
  logic [CW-1:0]        steps;
  logic                 ovf;
  particle_t            wk;
  particle_t            adv;
  particle_t            moved;
  particle_t            new_p;
  particle_t            cell_q [POOL_SIZE];
  particle_t            head;
  cell_ctl_t            ctl;
  logic [IW-1:0]        wr_idx;
  logic [POOL_SIZE-1:0] later_live;
  logic                 more;
  logic signed [33:0]   prod;
  logic                 neg;
  logic [31:0]          mag;
  logic                 div_busy;
  logic [31:0]          div_q;
  logic signed [16:0]   scale;
  logic signed [16:0]   d_se;
  logic signed [16:0]   q_s;
  logic                 can_emit;

  assign new_p = '{pos_x: pos_x, pos_y: pos_y, pos_z: pos_z,
                   vel_x: vel_x, vel_y: vel_y, vel_z: vel_z,
                   acc_x: acc_x, acc_y: acc_y, acc_z: acc_z,
                   life: life, age: 16'd0, look: appearance};

  assign head     = cell_q[0];
  assign in_stall = (state != S_IDLE);
  assign can_emit = !out_valid || !out_stall;
  assign wr_idx   = IW'(count - CW'(1));

  assign ctl.shr = (state == S_IDLE) && in_valid && (cmd == CMD_ADD)
                   && (count < CW'(POOL_SIZE));
  assign ctl.shl = (state == S_HEAD);
  assign ctl.wr  = (state == S_EMIT) && can_emit;

  for (genvar g = 0; g < POOL_SIZE; g++) begin : g_cell
    particle_t lft;
    particle_t rgt;
    if (g == 0) begin : g_first
      assign lft = new_p;
    end else begin : g_mid
      assign lft = cell_q[g-1];
    end
    if (g == POOL_SIZE - 1) begin : g_end
      assign rgt = '0;
    end else begin : g_next
      assign rgt = cell_q[g+1];
    end
    assign later_live[g] = (CW'(g + 1) < steps) && (cell_q[g].age < cell_q[g].life);
    ppu_cell #(.IDX(g), .IW(IW)) u_cell (
      .clk    (clk),
      .ctl    (ctl),
      .wr_idx (wr_idx),
      .left   (lft),
      .right  (rgt),
      .wdata  (wk),
      .q      (cell_q[g])
    );
  end

  assign more = |later_live;

  always_comb begin
    adv         = head;
    adv.age     = head.age + 16'd1;
    adv.vel_x   = sat_add(head.vel_x, head.acc_x);
    adv.vel_y   = sat_add(head.vel_y, head.acc_y);
    adv.vel_z   = sat_add(head.vel_z, head.acc_z);
    moved       = wk;
    moved.pos_x = sat_add(wk.pos_x, wk.vel_x);
    moved.pos_y = sat_add(wk.pos_y, wk.vel_y);
    moved.pos_z = sat_add(wk.pos_z, wk.vel_z);
  end

  assign d_se = $signed({1'b0, wk.look[47:32]}) - $signed({1'b0, wk.look[63:48]});
  assign neg  = prod[33];
  assign mag  = neg ? 32'(-prod) : prod[31:0];

  ppu_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_DIVS),
    .num   (mag),
    .den   (wk.life),
    .busy  (div_busy),
    .quot  (div_q)
  );

  assign q_s = neg ? -$signed(div_q[16:0]) : $signed(div_q[16:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      steps     <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (cmd == CMD_ADD) begin
              if (count < CW'(POOL_SIZE)) begin
                count <= count + CW'(1);
              end else begin
                ovf <= 1'b1;
              end
            end else if (count != '0) begin
              steps <= count;
              state <= S_HEAD;
            end
          end
        end
        S_HEAD: begin
          if (head.age >= head.life) begin
            count <= count - CW'(1);
            steps <= steps - CW'(1);
            if (steps == CW'(1)) begin
              state <= S_IDLE;
            end
          end else begin
            wk    <= adv;
            state <= S_POS;
          end
        end
        S_POS: begin
          wk    <= moved;
          prod  <= 34'(d_se * $signed({1'b0, wk.age}));
          state <= S_DIVS;
        end
        S_DIVS: begin
          state <= S_DIVW;
        end
        S_DIVW: begin
          if (!div_busy) begin
            scale <= $signed({1'b0, wk.look[63:48]}) + q_s;
            state <= S_FIN;
          end
        end
        S_FIN: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (can_emit) begin
            out_valid <= 1'b1;
            out_x     <= wk.pos_x;
            out_y     <= wk.pos_y;
            out_z     <= wk.pos_z;
            out_scale <= scale;
            out_color <= wk.look[31:0];
            overflow  <= ovf;
            last      <= !more;
            steps     <= steps - CW'(1);
            if (!more) begin
              ovf <= 1'b0;
            end
            if (steps == CW'(1)) begin
              state <= S_IDLE;
            end else begin
              state <= S_HEAD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
